// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the project.
// Needs nothing else; every macro takes the clock and reset it samples on.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold at the same edge as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold at the edge after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/dmst_pkg.sv =====
// Types and constants of the dual moving sum threshold alarm.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package dmst_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SAMPLE_MAX = 4095;
    localparam int SUM_W = 19;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;
    localparam logic [SUM_W-1:0] LIMIT_RESET = 19'd10000;

    typedef enum logic [0:0] {
        REG_TEMPERATURE_LIMIT = 1'b0,
        REG_LIGHT_LIMIT       = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] temperature_sample;
        logic [SAMPLE_W-1:0] light_sample;
    } sample_t;

    typedef struct packed {
        logic [SUM_W-1:0] temperature_window_sum;
        logic [SUM_W-1:0] light_window_sum;
        logic             over_limit;
    } result_t;

    typedef struct packed {
        logic [SUM_W-1:0] temperature_limit;
        logic [SUM_W-1:0] light_limit;
    } limits_t;

endpackage

// ===== sv/dmst_cell.sv =====
// One cell of the sample delay chain: holds one sample pair.
// Depends on dmst_pkg.
`timescale 1ns / 1ps

module dmst_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  dmst_pkg::sample_t d,
    output dmst_pkg::sample_t q
);
    import dmst_pkg::*;

    sample_t pair_reg;
    sample_t pair_next;

    assign pair_next = shift ? d : pair_reg;
    assign q = pair_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_reg <= '0;
        end
        else
        begin
            pair_reg <= pair_next;
        end
    end

endmodule

// ===== sv/dmst_acc.sv =====
// Running window totals and limit comparison.
// Depends on dmst_pkg; fed by the delay chain in the top level.
`timescale 1ns / 1ps

module dmst_acc #(
    parameter int TOTAL_W = 19
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  dmst_pkg::sample_t newest,
    input  dmst_pkg::sample_t oldest,
    input  dmst_pkg::limits_t limits,
    output dmst_pkg::result_t result
);
    import dmst_pkg::*;

    localparam int CMP_W = (TOTAL_W > SUM_W) ? TOTAL_W : SUM_W;

    logic [TOTAL_W-1:0] temp_total_reg;
    logic [TOTAL_W-1:0] temp_total_next;
    logic [TOTAL_W-1:0] light_total_reg;
    logic [TOTAL_W-1:0] light_total_next;

    assign temp_total_next = temp_total_reg - TOTAL_W'(oldest.temperature_sample)
                             + TOTAL_W'(newest.temperature_sample);
    assign light_total_next = light_total_reg - TOTAL_W'(oldest.light_sample)
                              + TOTAL_W'(newest.light_sample);

    always_comb
    begin
        result.temperature_window_sum = SUM_W'(temp_total_next);
        result.light_window_sum = SUM_W'(light_total_next);
        result.over_limit = (CMP_W'(temp_total_next) > CMP_W'(limits.temperature_limit))
                            || (CMP_W'(light_total_next) > CMP_W'(limits.light_limit));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_total_reg <= '0;
            light_total_reg <= '0;
        end
        else if (step)
        begin
            temp_total_reg <= temp_total_next;
            light_total_reg <= light_total_next;
        end
    end

endmodule

// ===== sv/dmst_outq.sv =====
// Two-entry result queue that parts the output handshake from the input side.
// Depends on dmst_pkg.
`timescale 1ns / 1ps

module dmst_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dmst_pkg::result_t push_data,
    output logic              full,
    output logic              result_valid,
    input  logic              result_stall,
    output dmst_pkg::result_t result
);
    import dmst_pkg::*;

    result_t     head_reg;
    result_t     tail_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        pop;

    assign result_valid = (count_reg != 2'd0);
    assign full = (count_reg == 2'd2);
    assign result = head_reg;
    assign pop = result_valid && !result_stall;
    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (count_reg == 2'd2)
            begin
                head_reg <= tail_reg;
            end
            else if (push)
            begin
                head_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                head_reg <= push_data;
            end
            else
            begin
                tail_reg <= push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/dual_moving_sum_threshold_alarm_top.sv =====
// Top level of the dual moving sum threshold alarm: delay chain, totals, queue, registers.
// Depends on dmst_pkg, dmst_cell, dmst_acc and dmst_outq.
//
// Channel   Direction  Handshake                     Payload
// sample    in         sample_valid / sample_stall   dmst_pkg::sample_t
// result    out        result_valid / result_stall   dmst_pkg::result_t
// config    in         psel / penable / pready       pwdata, prdata
//
// One item is taken every cycle unless the sample side stalls; its result is pushed to
// the queue on acceptance. The chain of WINDOW cells shifts once per item; its last cell
// gives the sample leaving the window, so add, subtract and compare are combinational.
// Reset clears the chain, the totals and the queue, and restores both limits.
// The sample side stalls only when both result queue entries are waiting.
`timescale 1ns / 1ps

module dual_moving_sum_threshold_alarm_top #(
    parameter int WINDOW = 100
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  dmst_pkg::sample_t                 sample,
    output logic                              result_valid,
    input  logic                              result_stall,
    output dmst_pkg::result_t                 result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dmst_pkg::PADDR_W-1:0]      paddr,
    input  logic [dmst_pkg::PDATA_W-1:0]      pwdata,
    output logic [dmst_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import dmst_pkg::*;

    localparam int TOTAL_W = $clog2(WINDOW * SAMPLE_MAX + 1);

    sample_t    chain [0:WINDOW];
    limits_t    limits_reg;
    limits_t    limits_next;
    result_t    step_result;
    logic       accept;
    logic       full;
    logic       cfg_write;
    reg_index_t reg_sel;

    assign accept = sample_valid && !full;
    assign sample_stall = full;
    assign chain[0] = sample;

    genvar i;
    generate
        for (i = 0; i < WINDOW; i++)
        begin : g_cell
            dmst_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (accept),
                .d     (chain[i]),
                .q     (chain[i+1])
            );
        end
    endgenerate

    dmst_acc #(
        .TOTAL_W (TOTAL_W)
    ) u_acc (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (accept),
        .newest (sample),
        .oldest (chain[WINDOW]),
        .limits (limits_reg),
        .result (step_result)
    );

    dmst_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (accept),
        .push_data    (step_result),
        .full         (full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel = reg_index_t'(paddr[2]);

    always_comb
    begin
        limits_next = limits_reg;
        prdata = '0;
        case (reg_sel)
            REG_TEMPERATURE_LIMIT:
            begin
                prdata = {{(PDATA_W-SUM_W){1'b0}}, limits_reg.temperature_limit};
                if (cfg_write)
                begin
                    limits_next.temperature_limit = pwdata[SUM_W-1:0];
                end
            end
            REG_LIGHT_LIMIT:
            begin
                prdata = {{(PDATA_W-SUM_W){1'b0}}, limits_reg.light_limit};
                if (cfg_write)
                begin
                    limits_next.light_limit = pwdata[SUM_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.temperature_limit <= LIMIT_RESET;
            limits_reg.light_limit <= LIMIT_RESET;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

endmodule

// ===== sv/dmst_checker.sv =====
// Port-level checker of the dual moving sum threshold alarm, bound to the top level.
// Depends on dmst_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dmst_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              sample_valid,
    input logic              sample_stall,
    input dmst_pkg::sample_t sample,
    input logic              result_valid,
    input logic              result_stall,
    input dmst_pkg::result_t result
);
    import dmst_pkg::*;

    // A waiting result holds until it is taken.
    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))

    // A stalled item stays offered unchanged until it is taken.
    `ASSERT_NEXT(a_sample_hold, clk, rst_n, sample_valid && sample_stall, sample_valid && $stable(sample))

    // Every accepted item leaves a result to be shown at the next edge.
    `ASSERT_NEXT(a_item_gives_result, clk, rst_n, sample_valid && !sample_stall, result_valid)

    // The sample side only starts stalling after a result was held back.
    `ASSERT_SAME(a_stall_cause, clk, rst_n, $rose(sample_stall), $past(result_valid && result_stall))

    // The result side only empties by handing over its last item.
    `ASSERT_SAME(a_empty_cause, clk, rst_n, $fell(result_valid), $past(!result_stall && !sample_stall))

endmodule

bind dual_moving_sum_threshold_alarm_top dmst_checker u_dmst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ===== tb/tb_dual_moving_sum_threshold_alarm_top.sv =====
// Self-checking testbench for the dual moving sum threshold alarm top level.
// Drives samples and limit writes, predicts each result with its own moving-window model.
// Depends on dmst_pkg and dual_moving_sum_threshold_alarm_top.
`timescale 1ns / 1ps

module tb_dual_moving_sum_threshold_alarm_top;

    import dmst_pkg::*;

    localparam int WINDOW = 100;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 168;
    localparam int HOLD_CYCLES = 150;
    localparam int MAX_SUM = 409500;

    class window_sum_checker;
        logic [SAMPLE_W-1:0] temp_ring [WINDOW];
        logic [SAMPLE_W-1:0] light_ring [WINDOW];
        int unsigned slot;
        int unsigned temp_total;
        int unsigned light_total;
        logic [SUM_W-1:0] temp_limit;
        logic [SUM_W-1:0] light_limit;
        result_t pending_sums[$];
        int unsigned mismatches;
        int unsigned samples_seen;
        int unsigned results_checked;
        int unsigned alarms_seen;

        function new();
            foreach (temp_ring[i])
            begin
                temp_ring[i] = '0;
                light_ring[i] = '0;
            end
            slot = 0;
            temp_total = 0;
            light_total = 0;
            temp_limit = LIMIT_RESET;
            light_limit = LIMIT_RESET;
            mismatches = 0;
            samples_seen = 0;
            results_checked = 0;
            alarms_seen = 0;
        endfunction

        function void set_limit(reg_index_t idx, logic [PDATA_W-1:0] value);
            if (idx == REG_TEMPERATURE_LIMIT)
                temp_limit = value[SUM_W-1:0];
            else
                light_limit = value[SUM_W-1:0];
        endfunction

        function logic [SUM_W-1:0] limit_of(reg_index_t idx);
            return (idx == REG_TEMPERATURE_LIMIT) ? temp_limit : light_limit;
        endfunction

        function int pending();
            return pending_sums.size();
        endfunction

        function void compare(string what, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH %s: expected %0d, actual %0d", what, want, got);
            end
        endfunction

        function void note_sample(sample_t s);
            result_t r;
            temp_total = temp_total - temp_ring[slot] + s.temperature_sample;
            light_total = light_total - light_ring[slot] + s.light_sample;
            r.temperature_window_sum = SUM_W'(temp_total);
            r.light_window_sum = SUM_W'(light_total);
            r.over_limit = (temp_total > temp_limit) || (light_total > light_limit);
            temp_ring[slot] = s.temperature_sample;
            light_ring[slot] = s.light_sample;
            slot = (slot + 1 == WINDOW) ? 0 : slot + 1;
            samples_seen++;
            pending_sums.push_back(r);
        endfunction

        function void check_result(result_t r);
            result_t want;
            results_checked++;
            if (r.over_limit)
                alarms_seen++;
            if (pending_sums.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH unexpected result: sums %0d / %0d, alarm %0d",
                             r.temperature_window_sum, r.light_window_sum, r.over_limit);
            end
            else
            begin
                want = pending_sums.pop_front();
                compare("temperature window sum", want.temperature_window_sum,
                        r.temperature_window_sum);
                compare("light window sum", want.light_window_sum, r.light_window_sum);
                compare("over limit", want.over_limit, r.over_limit);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 sample_valid;
    logic                 sample_stall;
    sample_t              sample;
    logic                 result_valid;
    logic                 result_stall;
    result_t              result;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    window_sum_checker window_sums;
    bit no_idle;
    int unsigned hold_requests;
    int unsigned holds_done;
    int unsigned input_stall_cycles;

    dual_moving_sum_threshold_alarm_top #(
        .WINDOW(WINDOW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample(sample),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
                window_sums.note_sample(sample);
            if (sample_valid && sample_stall)
                input_stall_cycles++;
            if (result_valid && !result_stall)
                window_sums.check_result(result);
        end
    end

    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            else
            begin
                result_stall <= !no_idle && ($urandom_range(0, 99) < 7);
            end
        end
    end

    task automatic send_item(input logic [SAMPLE_W-1:0] t, input logic [SAMPLE_W-1:0] l);
        @(negedge clk);
        while (!no_idle && ($urandom_range(0, 99) < 7))
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample <= '{temperature_sample: t, light_sample: l};
        do
            @(posedge clk);
        while (sample_stall);
    endtask

    task automatic drain();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (window_sums.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(input reg_index_t idx, input bit wr,
                              input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_limits(input logic [PDATA_W-1:0] temp_word,
                              input logic [PDATA_W-1:0] light_word);
        logic [PDATA_W-1:0] readback;
        apb_access(REG_TEMPERATURE_LIMIT, 1'b1, temp_word, readback);
        window_sums.set_limit(REG_TEMPERATURE_LIMIT, temp_word);
        apb_access(REG_LIGHT_LIMIT, 1'b1, light_word, readback);
        window_sums.set_limit(REG_LIGHT_LIMIT, light_word);
        apb_access(REG_TEMPERATURE_LIMIT, 1'b0, '0, readback);
        window_sums.compare("temperature limit readback",
                            window_sums.limit_of(REG_TEMPERATURE_LIMIT), readback);
        apb_access(REG_LIGHT_LIMIT, 1'b0, '0, readback);
        window_sums.compare("light limit readback",
                            window_sums.limit_of(REG_LIGHT_LIMIT), readback);
    endtask

    function automatic logic [PDATA_W-1:0] limit_near(int centre);
        int lim;
        lim = centre + int'($urandom_range(0, 16000)) - 8000;
        if (lim < 0)
            lim = 0;
        if (lim > MAX_SUM)
            lim = MAX_SUM;
        return {13'($urandom()), 19'(lim)};
    endfunction

    initial
    begin
        int unsigned lo;
        int unsigned hi;
        logic [SAMPLE_W-1:0] t;
        logic [SAMPLE_W-1:0] l;

        window_sums = new();
        no_idle = 1'b0;
        hold_requests = 0;
        holds_done = 0;
        input_stall_cycles = 0;
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The ring still holds zeros here, so each sum covers only the samples so far.
        // Both sums land exactly on the reset limit and then go one above it.
        send_item(12'd0, 12'd0);
        send_item(12'd4095, 12'd4095);
        send_item(12'd4095, 12'd4095);
        send_item(12'd1810, 12'd1810);
        send_item(12'd0, 12'd1);
        send_item(12'd1, 12'd0);
        send_item(12'hAAA, 12'h555);
        send_item(12'h555, 12'hAAA);
        send_item(12'd4095, 12'd0);
        send_item(12'd0, 12'd4095);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            lo = 0;
            hi = SAMPLE_MAX;
            case (p)
                0: set_limits(32'hFFF8_0000, 32'hFFF8_0000);
                1: set_limits(32'(MAX_SUM), 32'(MAX_SUM));
                2: set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                default:
                begin
                    lo = $urandom_range(0, SAMPLE_MAX);
                    hi = $urandom_range(lo, SAMPLE_MAX);
                    set_limits(limit_near(50 * (lo + hi)), limit_near(50 * (lo + hi)));
                end
            endcase
            no_idle = (p == 5);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if ((p == 3 || p == 6) && i == ITEMS_PER_PHASE / 2)
                    hold_requests++;
                if ($urandom_range(0, 9) == 0)
                    t = $urandom_range(0, 1) ? 12'(SAMPLE_MAX) : 12'd0;
                else
                    t = SAMPLE_W'($urandom_range(lo, hi));
                if ($urandom_range(0, 9) == 0)
                    l = $urandom_range(0, 1) ? 12'(SAMPLE_MAX) : 12'd0;
                else
                    l = SAMPLE_W'($urandom_range(lo, hi));
                send_item(t, l);
            end
            drain();
        end
        no_idle = 1'b0;
        repeat (10) @(posedge clk);

        $display("Run covered %0d samples and %0d results over %0d limit settings.",
                 window_sums.samples_seen, window_sums.results_checked, PHASES + 1);
        $display("Alarm raised on %0d results; the sample side stalled for %0d cycles.",
                 window_sums.alarms_seen, input_stall_cycles);
        if (window_sums.mismatches == 0 && window_sums.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
